/* src/cmc_pkg.sv */
// Package for the two-button chord menu selector.
// Gesture codes, gesture-machine states, register indexes and shared structs.
// No dependencies.
`default_nettype none
package cmc_pkg;

  localparam int unsigned RegW = 8;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_OPTION_COUNT = 1'd0;
  localparam cfg_idx_t REG_POLL_INTERVAL = 1'd1;

  localparam logic [RegW-1:0] OPTION_COUNT_RST = 8'd1;
  localparam logic [RegW-1:0] POLL_INTERVAL_RST = 8'd60;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_LEFT  = 2'd1,
    GEST_RIGHT = 2'd2,
    GEST_BOTH  = 2'd3
  } gesture_t;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_LEFT_DOWN  = 5'b00010,
    ST_RIGHT_DOWN = 5'b00100,
    ST_BOTH_DOWN  = 5'b01000,
    ST_WAIT_UP    = 5'b10000
  } gest_state_t;

  typedef struct packed {
    logic            menu_active;
    logic [RegW-1:0] menu_index;
    logic            select_strobe;
    logic            forward_left;
    logic            forward_right;
  } menu_res_t;

endpackage
`default_nettype wire

/* src/cmc_ifs.sv */
// Valid/ready channel interfaces for the chord menu selector.
// Tick channel carries button levels; result channel carries menu outputs.
`default_nettype none
interface cmc_in_if;
  logic valid;
  logic ready;
  logic left_pressed;
  logic right_pressed;
  modport source (output valid, output left_pressed, output right_pressed, input ready);
  modport sink (input valid, input left_pressed, input right_pressed, output ready);
endinterface

interface cmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;
  logic       menu_active;
  logic [7:0] menu_index;
  logic       select_strobe;
  logic       forward_left;
  logic       forward_right;
  modport source (output valid, output gesture, output menu_active, output menu_index,
                  output select_strobe, output forward_left, output forward_right,
                  input ready);
  modport sink (input valid, input gesture, input menu_active, input menu_index,
                input select_strobe, input forward_left, input forward_right,
                output ready);
endinterface
`default_nettype wire

/* src/cmc_gesture.sv */
// Gesture state machine: turns sampled button levels into left/right/chord.
// Depends on cmc_pkg.
`default_nettype none
module cmc_gesture (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample,
  input  wire logic              left_pressed,
  input  wire logic              right_pressed,
  output cmc_pkg::gesture_t      gesture
);

  cmc_pkg::gest_state_t state, state_next;
  logic up;

  assign up = !left_pressed && !right_pressed;

  always_comb begin
    state_next = state;
    gesture = cmc_pkg::GEST_NONE;
    case (state)
      cmc_pkg::ST_IDLE: begin
        if (left_pressed && right_pressed) state_next = cmc_pkg::ST_BOTH_DOWN;
        else if (left_pressed) state_next = cmc_pkg::ST_LEFT_DOWN;
        else if (right_pressed) state_next = cmc_pkg::ST_RIGHT_DOWN;
      end
      cmc_pkg::ST_LEFT_DOWN: begin
        if (right_pressed) state_next = cmc_pkg::ST_BOTH_DOWN;
        else if (up) begin
          gesture = cmc_pkg::GEST_LEFT;
          state_next = cmc_pkg::ST_IDLE;
        end
      end
      cmc_pkg::ST_RIGHT_DOWN: begin
        if (left_pressed) state_next = cmc_pkg::ST_BOTH_DOWN;
        else if (up) begin
          gesture = cmc_pkg::GEST_RIGHT;
          state_next = cmc_pkg::ST_IDLE;
        end
      end
      cmc_pkg::ST_BOTH_DOWN: state_next = cmc_pkg::ST_WAIT_UP;
      cmc_pkg::ST_WAIT_UP: begin
        if (up) begin
          gesture = cmc_pkg::GEST_BOTH;
          state_next = cmc_pkg::ST_IDLE;
        end
      end
      default: state_next = cmc_pkg::ST_IDLE;
    endcase
    if (!sample) begin
      state_next = state;
      gesture = cmc_pkg::GEST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cmc_pkg::ST_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

/* src/cmc_menu.sv */
// Menu mode and highlighted index; decides select and forwarding strobes.
// Depends on cmc_pkg.
`default_nettype none
module cmc_menu (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire cmc_pkg::gesture_t           gesture,
  input  wire logic [cmc_pkg::RegW-1:0]    option_count,
  output cmc_pkg::menu_res_t               res
);

  logic                     menu_flag, menu_flag_next;
  logic [cmc_pkg::RegW-1:0] index, index_next;
  logic [cmc_pkg::RegW-1:0] count, last;

  assign count = (option_count == '0) ? cmc_pkg::RegW'(1) : option_count;
  assign last = count - cmc_pkg::RegW'(1);

  always_comb begin
    menu_flag_next = menu_flag;
    index_next = index;
    res.select_strobe = 1'b0;
    res.forward_left = 1'b0;
    res.forward_right = 1'b0;
    case (gesture)
      cmc_pkg::GEST_BOTH: begin
        res.select_strobe = menu_flag;
        menu_flag_next = !menu_flag;
      end
      cmc_pkg::GEST_LEFT: begin
        if (menu_flag)
          index_next = (index == '0 || index >= count) ? last : index - cmc_pkg::RegW'(1);
        else
          res.forward_left = 1'b1;
      end
      cmc_pkg::GEST_RIGHT: begin
        if (menu_flag)
          index_next = (index >= last) ? '0 : index + cmc_pkg::RegW'(1);
        else
          res.forward_right = 1'b1;
      end
      default: ;
    endcase
    res.menu_active = menu_flag_next;
    res.menu_index = index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_flag <= 1'b0;
      index <= '0;
    end else if (en) begin
      menu_flag <= menu_flag_next;
      index <= index_next;
    end
  end

endmodule
`default_nettype wire

/* src/two_button_chord_menu_selector.sv */
// Two-button chord menu selector: prescaled button sampling, gesture machine,
// menu index stepping and select strobe. Depends on cmc_pkg, cmc_ifs,
// cmc_gesture and cmc_menu.
//
// Each tick word yields exactly one result word. A tick lands in an input
// register, and the prescaler, gesture machine and menu update run in one
// pass from there into the result register, so one tick is taken per cycle
// unless stalled, and its result word is presented from the result register.
// Ready follows the result register: the block stalls only while a result
// waits on a stalled sink.
// Configuration writes (index 0 option_count, index 1 poll_interval) are
// meant for idle periods.
`default_nettype none
module two_button_chord_menu_selector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  cmc_in_if.sink                             in_ch,
  cmc_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire cmc_pkg::cfg_idx_t             cfg_idx,
  input  wire logic [cmc_pkg::RegW-1:0]      cfg_data
);

  logic [cmc_pkg::RegW-1:0] option_count, poll_interval, tick_counter;
  logic                     in_valid, in_left, in_right;
  logic                     out_valid, advance, sample;
  cmc_pkg::gesture_t        gesture;
  cmc_pkg::menu_res_t       res;

  assign advance = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign sample = advance && (tick_counter >= poll_interval);

  always_ff @(posedge clk) begin
    if (rst) begin
      option_count <= cmc_pkg::OPTION_COUNT_RST;
      poll_interval <= cmc_pkg::POLL_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cmc_pkg::REG_OPTION_COUNT: option_count <= cfg_data;
        cmc_pkg::REG_POLL_INTERVAL: poll_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance)
        tick_counter <= (tick_counter >= poll_interval) ? '0
                        : tick_counter + cmc_pkg::RegW'(1);
      if (in_ch.ready) in_valid <= in_ch.valid;
      if (!out_valid || out_ch.ready) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_left <= in_ch.left_pressed;
      in_right <= in_ch.right_pressed;
    end
    if (advance) begin
      out_ch.gesture <= gesture;
      out_ch.menu_active <= res.menu_active;
      out_ch.menu_index <= res.menu_index;
      out_ch.select_strobe <= res.select_strobe;
      out_ch.forward_left <= res.forward_left;
      out_ch.forward_right <= res.forward_right;
    end
  end

  assign out_ch.valid = out_valid;

  cmc_gesture u_gesture (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .left_pressed  (in_left),
    .right_pressed (in_right),
    .gesture       (gesture)
  );

  cmc_menu u_menu (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .gesture      (gesture),
    .option_count (option_count),
    .res          (res)
  );

endmodule
`default_nettype wire

/* tb/tb_two_button_chord_menu_selector.sv */
// Self-checking testbench for two_button_chord_menu_selector.
// Drives button-level tick words and predicts each result word from its own copy of
// the prescaler, gesture machine and menu state. Depends on cmc_pkg and cmc_ifs.
module tb_two_button_chord_menu_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import cmc_pkg::*;

  typedef struct packed {
    gesture_t  gesture;
    menu_res_t res;
  } menu_word_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  cfg_idx_t        cfg_idx;
  logic [RegW-1:0] cfg_data;

  cmc_in_if  tick_ch ();
  cmc_out_if res_ch ();

  two_button_chord_menu_selector i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (tick_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [7:0]  opt_cnt;
  logic [7:0]  poll_ivl;
  logic [7:0]  pace_cnt;
  gest_state_t chord_st;
  logic        in_menu;
  logic [7:0]  hl_idx;

  logic [1:0]  level_q [$];
  menu_word_t  expected_menu_q [$];
  int unsigned budget;
  int unsigned errors;
  int unsigned rx_count;
  int unsigned tx_gap;
  int unsigned rx_hold;
  logic        held_long;
  logic        calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic menu_word_t next_menu_word(logic l, logic r);
    menu_word_t  w;
    int unsigned count;
    int unsigned last;
    int unsigned idx;
    logic        up;
    w = '0;
    w.gesture = GEST_NONE;
    up = !l && !r;
    if (pace_cnt >= poll_ivl) begin
      pace_cnt = '0;
      case (chord_st)
        ST_IDLE: begin
          if (l && r) chord_st = ST_BOTH_DOWN;
          else if (l) chord_st = ST_LEFT_DOWN;
          else if (r) chord_st = ST_RIGHT_DOWN;
        end
        ST_LEFT_DOWN: begin
          if (r) chord_st = ST_BOTH_DOWN;
          else if (up) begin
            w.gesture = GEST_LEFT;
            chord_st = ST_IDLE;
          end
        end
        ST_RIGHT_DOWN: begin
          if (l) chord_st = ST_BOTH_DOWN;
          else if (up) begin
            w.gesture = GEST_RIGHT;
            chord_st = ST_IDLE;
          end
        end
        ST_BOTH_DOWN: begin
          chord_st = ST_WAIT_UP;
        end
        ST_WAIT_UP: begin
          if (up) begin
            w.gesture = GEST_BOTH;
            chord_st = ST_IDLE;
          end
        end
        default: begin
          chord_st = ST_IDLE;
        end
      endcase
    end else begin
      pace_cnt = pace_cnt + 8'd1;
    end

    if (w.gesture == GEST_BOTH) begin
      if (in_menu) begin
        w.res.select_strobe = 1'b1;
        in_menu = 1'b0;
      end else begin
        in_menu = 1'b1;
      end
    end else if (w.gesture != GEST_NONE) begin
      if (in_menu) begin
        count = (opt_cnt != 0) ? opt_cnt : 1;
        last = count - 1;
        idx = hl_idx;
        if (w.gesture == GEST_LEFT) idx = (idx == 0 || idx >= count) ? last : idx - 1;
        else idx = (idx >= last) ? 0 : idx + 1;
        hl_idx = 8'(idx);
      end else if (w.gesture == GEST_LEFT) begin
        w.res.forward_left = 1'b1;
      end else begin
        w.res.forward_right = 1'b1;
      end
    end
    w.res.menu_active = in_menu;
    w.res.menu_index = hl_idx;
    return w;
  endfunction

  // alternate between gapped traffic and back-to-back stretches
  always begin
    repeat ($urandom_range(50, 300)) @(posedge clk);
    calm <= ($urandom_range(0, 3) == 0);
  end

  // tick driver
  always @(posedge clk) begin : tick_driver
    logic [1:0] lv;
    if (rst) begin
      tick_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready)
        expected_menu_q.push_back(next_menu_word(tick_ch.left_pressed, tick_ch.right_pressed));
      if (!tick_ch.valid || tick_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          tick_ch.valid <= 1'b0;
        end else if (level_q.size() > 0) begin
          lv = level_q.pop_front();
          tick_ch.valid <= 1'b1;
          tick_ch.left_pressed <= lv[1];
          tick_ch.right_pressed <= lv[0];
          tx_gap <= pick_gap();
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink back-pressure
  always @(posedge clk) begin : result_monitor
    menu_word_t  want;
    int unsigned gap;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_hold <= 0;
      held_long <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        rx_count++;
        if (expected_menu_q.size() == 0) begin
          report_mismatch("result word with no expectation pending");
        end else begin
          want = expected_menu_q.pop_front();
          if (res_ch.gesture !== want.gesture)
            report_mismatch($sformatf("gesture got %0d want %0d", res_ch.gesture,
                                      want.gesture));
          if (res_ch.menu_active !== want.res.menu_active)
            report_mismatch($sformatf("menu_active got %0b want %0b", res_ch.menu_active,
                                      want.res.menu_active));
          if (res_ch.menu_index !== want.res.menu_index)
            report_mismatch($sformatf("menu_index got %0d want %0d", res_ch.menu_index,
                                      want.res.menu_index));
          if (res_ch.select_strobe !== want.res.select_strobe)
            report_mismatch($sformatf("select_strobe got %0b want %0b", res_ch.select_strobe,
                                      want.res.select_strobe));
          if (res_ch.forward_left !== want.res.forward_left)
            report_mismatch($sformatf("forward_left got %0b want %0b", res_ch.forward_left,
                                      want.res.forward_left));
          if (res_ch.forward_right !== want.res.forward_right)
            report_mismatch($sformatf("forward_right got %0b want %0b", res_ch.forward_right,
                                      want.res.forward_right));
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        res_ch.ready <= (rx_hold == 1);
      end else if (!held_long && rx_count >= 300) begin
        // long hold-off so the block fills and stalls its input
        held_long <= 1'b1;
        rx_hold <= 120;
        res_ch.ready <= 1'b0;
      end else if (res_ch.valid && res_ch.ready) begin
        gap = pick_gap();
        rx_hold <= gap;
        res_ch.ready <= (gap == 0);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_level(bit l, bit r, int unsigned n);
    repeat (n) begin
      if (budget > 0) begin
        level_q.push_back({l, r});
        budget--;
      end
    end
  endtask

  function automatic int unsigned hold_len(int unsigned span);
    return $urandom_range(span, 2 * span);
  endfunction

  task automatic push_gesture(int unsigned span);
    case ($urandom_range(0, 9))
      0, 1: begin
        push_level(1, 0, hold_len(span));
        push_level(0, 0, hold_len(span));
      end
      2, 3: begin
        push_level(0, 1, hold_len(span));
        push_level(0, 0, hold_len(span));
      end
      4, 5: begin
        push_level(1, 1, hold_len(span));
        push_level(0, 0, $urandom_range(2 * span, 3 * span));
      end
      6: begin
        push_level(1, 0, hold_len(span));
        push_level(1, 1, hold_len(span));
        push_level(0, 1, hold_len(span));
        push_level(0, 0, $urandom_range(2 * span, 3 * span));
      end
      7: begin
        push_level(0, 1, hold_len(span));
        push_level(1, 0, hold_len(span));
        push_level(0, 0, $urandom_range(2 * span, 3 * span));
      end
      8: begin
        repeat (4) push_level($urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(1, span));
      end
      default: begin
        repeat ($urandom_range(2, 8)) push_level($urandom_range(0, 1),
                                                 $urandom_range(0, 1), 1);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (level_q.size() != 0 || tick_ch.valid || expected_menu_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] opt, logic [7:0] poll);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_OPTION_COUNT;
    cfg_data <= opt;
    @(posedge clk);
    cfg_idx <= REG_POLL_INTERVAL;
    cfg_data <= poll;
    @(posedge clk);
    cfg_we <= 1'b0;
    opt_cnt = opt;
    poll_ivl = poll;
  endtask

  initial begin : stimulus
    logic [7:0]  ph_opt  [9] = '{8'd7, 8'd255, 8'd5, 8'd0, 8'd1, 8'd255, 8'd2, 8'd200, 8'd4};
    logic [7:0]  ph_poll [9] = '{8'd1, 8'd0, 8'd2, 8'd0, 8'd3, 8'd4, 8'd0, 8'd60, 8'd255};
    int unsigned ph_len  [9] = '{450, 300, 200, 100, 120, 200, 150, 120, 60};
    // left, right, chord in, step down, step up twice, staggered chord out
    logic [1:0]  directed [17] = '{2'b10, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00, 2'b00,
                                   2'b10, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00,
                                   2'b10, 2'b11, 2'b01, 2'b00};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_OPTION_COUNT;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.left_pressed = 1'b0;
    tick_ch.right_pressed = 1'b0;
    res_ch.ready = 1'b0;
    calm = 1'b0;
    errors = 0;
    rx_count = 0;
    opt_cnt = OPTION_COUNT_RST;
    poll_ivl = POLL_INTERVAL_RST;
    pace_cnt = '0;
    chord_st = ST_IDLE;
    in_menu = 1'b0;
    hl_idx = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: non-sample ticks only
    budget = 4;
    push_level(1, 1, 1);
    push_level(0, 0, 1);
    push_level(1, 0, 1);
    push_level(0, 1, 1);
    wait_drained();

    // counter now above the new interval, first tick samples
    write_regs(8'd3, 8'd0);
    budget = 17;
    foreach (directed[i]) push_level(directed[i][1], directed[i][0], 1);

    foreach (ph_len[p]) begin
      wait_drained();
      write_regs(ph_opt[p], ph_poll[p]);
      budget = ph_len[p];
      while (budget > 0) push_gesture(int'(ph_poll[p]) + 1);
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
